// ===== src/rgblut_pkg.sv =====
// Shared types and constants for the per-channel RGB lookup-table pipeline.
// Used by rgblut_chan, rgb_1d_lut_interp_blend, rgblut_chk and the testbench; depends on nothing.
package rgblut_pkg;

	// Number of pipeline register stages from the input beat to the result register.
	localparam int NUM_STAGES = 5;

	// Field widths fixed by the interface.
	localparam int PIX_W   = 8;
	localparam int ENTRY_W = 13;
	localparam int SIZE_W  = 9;
	localparam int INTEN_W = 7;
	localparam int INDEX_W = 8;

	// Internal datapath widths.
	localparam int POS_W = PIX_W + SIZE_W;       // p * (S - 1)
	localparam int LUT_W = ENTRY_W + PIX_W;      // interpolated entry times 255
	localparam int NUM_W = 28;                   // blend numerator, at most 208870500
	localparam int Y_W   = NUM_W - 12;           // numerator with the Q1.12 scale removed

	// Command codes of an input beat.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_INTENSITY  = 1'b0;
	localparam logic CFG_TABLE_SIZE = 1'b1;

	localparam logic [INTEN_W-1:0] INTENSITY_MAX = 7'd100;
	localparam logic [SIZE_W-1:0]  SIZE_MIN      = 9'd2;

	// Division by 100 as a multiply by a reciprocal; exact for values below SAT_LIMIT.
	localparam logic [12:0]    DIV100_RECIP = 13'd5243;
	localparam int             DIV100_SHIFT = 19;
	localparam logic [Y_W-1:0] SAT_LIMIT    = 16'd25600;

	// Per-stage load enables and the table write strobe shared by all channels.
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic                  wr_en;
		logic [INDEX_W-1:0]    wr_index;
	} pipe_ctl_t;

endpackage

// ===== src/rgblut_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// Stands alone; no package needed.
module rgblut_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr_a,
	input  logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic [WIDTH-1:0]           rdata_a,
	output logic [WIDTH-1:0]           rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Both read ports register their data and hold it while the read enable is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== src/rgblut_chan.sv =====
// Datapath of one color channel: position, table read, interpolation, blend, scaling.
// Depends on rgblut_pkg and rgblut_ram.
module rgblut_chan #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                              clk,
	input  rgblut_pkg::pipe_ctl_t             ctl,
	input  logic [rgblut_pkg::PIX_W-1:0]      pixel,
	input  logic [rgblut_pkg::ENTRY_W-1:0]    entry,
	input  logic [rgblut_pkg::SIZE_W-1:0]     size_m1,
	input  logic [rgblut_pkg::SIZE_W-1:0]     size_m2,
	input  logic [rgblut_pkg::INTEN_W-1:0]    inten,
	input  logic [rgblut_pkg::INTEN_W-1:0]    inten_c,
	output logic [rgblut_pkg::PIX_W-1:0]      result
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [rgblut_pkg::PIX_W-1:0]   pix_s1;
	logic [rgblut_pkg::POS_W-1:0]   pos_s1;
	logic [rgblut_pkg::ENTRY_W-1:0] entry_s1;

	logic [rgblut_pkg::SIZE_W-1:0]  quot;
	logic [9:0]                     rem;
	logic [rgblut_pkg::SIZE_W-1:0]  idx0;
	logic [rgblut_pkg::SIZE_W-1:0]  idx1;
	logic [rgblut_pkg::PIX_W-1:0]   frac;

	logic [rgblut_pkg::PIX_W-1:0]   pix_s2;
	logic [rgblut_pkg::PIX_W-1:0]   frac_s2;
	logic [rgblut_pkg::ENTRY_W-1:0] lo_s2;
	logic [rgblut_pkg::ENTRY_W-1:0] hi_s2;
	logic [rgblut_pkg::PIX_W-1:0]   frac_c;

	logic [rgblut_pkg::LUT_W-1:0]   lut_s3;
	logic [14:0]                    keep_s3;

	logic [rgblut_pkg::NUM_W-1:0]   num_s4;

	logic [rgblut_pkg::Y_W-1:0]     yval;
	logic [27:0]                    yprod;
	logic [rgblut_pkg::PIX_W-1:0]   scaled;
	logic [rgblut_pkg::PIX_W-1:0]   result_s5;

	// Stage 1: register the beat and form the table position p * (S - 1).
	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			pix_s1   <= pixel;
			pos_s1   <= rgblut_pkg::POS_W'(pixel) * rgblut_pkg::POS_W'(size_m1);
			entry_s1 <= entry;
		end
	end

	// Split the position by 255: start from pos / 256 and correct at most twice.
	// The last pixel code lands one entry too far and is pulled back with a full fraction.
	always_comb begin
		quot = pos_s1[rgblut_pkg::POS_W-1:8];
		rem  = 10'(pos_s1[7:0]) + 10'(pos_s1[rgblut_pkg::POS_W-1:8]);
		if (rem >= 10'd255) begin
			quot = quot + 9'd1;
			rem  = rem - 10'd255;
		end
		if (rem >= 10'd255) begin
			quot = quot + 9'd1;
			rem  = rem - 10'd255;
		end
		if (quot > size_m2) begin
			idx0 = size_m2;
			frac = 8'd255;
		end else begin
			idx0 = quot;
			frac = rem[7:0];
		end
		idx1 = idx0 + 9'd1;
	end

	// Table storage; writes and reads both happen as a beat leaves stage 1, so they stay in order.
	rgblut_ram #(
		.WIDTH (rgblut_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ctl.wr_en),
		.waddr   (AW'(ctl.wr_index)),
		.wdata   (entry_s1),
		.re      (ctl.load[1]),
		.raddr_a (AW'(idx0)),
		.raddr_b (AW'(idx1)),
		.rdata_a (lo_s2),
		.rdata_b (hi_s2)
	);

	// Stage 2: pixel and fraction travel beside the registered table reads.
	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			pix_s2  <= pix_s1;
			frac_s2 <= frac;
		end
	end

	assign frac_c = 8'd255 - frac_s2;

	// Stage 3: linear interpolation between the two neighboring entries, and the kept share of p.
	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			lut_s3  <= rgblut_pkg::LUT_W'(lo_s2) * rgblut_pkg::LUT_W'(frac_c)
				+ rgblut_pkg::LUT_W'(hi_s2) * rgblut_pkg::LUT_W'(frac_s2);
			keep_s3 <= 15'(pix_s2) * 15'(inten_c);
		end
	end

	// Stage 4: blend numerator p * 4096 * (100 - I) + lut * I.
	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			num_s4 <= rgblut_pkg::NUM_W'(lut_s3) * rgblut_pkg::NUM_W'(inten)
				+ {1'b0, keep_s3, 12'd0};
		end
	end

	// Divide by 409600: drop the Q1.12 scale, saturate, then divide by 100 through a reciprocal.
	always_comb begin
		yval  = num_s4[rgblut_pkg::NUM_W-1:12];
		yprod = 28'(yval[14:0]) * 28'(rgblut_pkg::DIV100_RECIP);
		if (yval >= rgblut_pkg::SAT_LIMIT) begin
			scaled = 8'd255;
		end else begin
			scaled = yprod[rgblut_pkg::DIV100_SHIFT +: rgblut_pkg::PIX_W];
		end
	end

	// Stage 5: result register.
	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			result_s5 <= scaled;
		end
	end

	assign result = result_s5;

endmodule

// ===== src/rgb_1d_lut_interp_blend.sv =====
// Top level: configuration registers, pipeline valid and stall control, three channels.
// Depends on rgblut_pkg and rgblut_chan.

// Maps each channel of an 8-bit RGB pixel through its own interpolated 1D table and blends
// the result with the original by the intensity register. The block takes one beat per
// clock cycle unless a result stall has filled the pipeline; a table-write beat gives no
// result. Throughput is one beat per cycle because each channel's table is a RAM with two
// read ports, so both neighboring entries are read in the same cycle. A stall at the
// result register backs up only as far as the pipeline is full, so beats keep being
// accepted into empty stages. Tables must be written before pixels read them; users must
// write configuration only while the pipeline is empty; the block does not enforce it.
module rgb_1d_lut_interp_blend #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [rgblut_pkg::SIZE_W-1:0]     cfg_data,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic                              command,
	input  logic [rgblut_pkg::INDEX_W-1:0]    table_index,
	input  logic [rgblut_pkg::ENTRY_W-1:0]    entry_red,
	input  logic [rgblut_pkg::ENTRY_W-1:0]    entry_green,
	input  logic [rgblut_pkg::ENTRY_W-1:0]    entry_blue,
	input  logic [rgblut_pkg::PIX_W-1:0]      pixel_red,
	input  logic [rgblut_pkg::PIX_W-1:0]      pixel_green,
	input  logic [rgblut_pkg::PIX_W-1:0]      pixel_blue,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [rgblut_pkg::PIX_W-1:0]      out_red,
	output logic [rgblut_pkg::PIX_W-1:0]      out_green,
	output logic [rgblut_pkg::PIX_W-1:0]      out_blue
);

	localparam logic [rgblut_pkg::SIZE_W-1:0] SIZE_CAP =
		9'((TABLE_DEPTH < 511) ? TABLE_DEPTH : 511);
	localparam logic [rgblut_pkg::SIZE_W-1:0] SIZE_RST =
		9'((TABLE_DEPTH < 256) ? TABLE_DEPTH : 256);

	logic [rgblut_pkg::INTEN_W-1:0] inten_q;
	logic [rgblut_pkg::INTEN_W-1:0] inten_c_q;
	logic [rgblut_pkg::SIZE_W-1:0]  size_m1_q;
	logic [rgblut_pkg::SIZE_W-1:0]  size_m2_q;
	logic [rgblut_pkg::INTEN_W-1:0] inten_new;
	logic [rgblut_pkg::SIZE_W-1:0]  size_new;

	logic                           vld_s1;
	logic                           vld_s2;
	logic                           vld_s3;
	logic                           vld_s4;
	logic                           vld_s5;
	logic                           cmd_s1;
	logic [rgblut_pkg::INDEX_W-1:0] index_s1;
	logic                           index_ok;
	logic [rgblut_pkg::NUM_STAGES-1:0] adv;
	rgblut_pkg::pipe_ctl_t          ctl;

	assign cfg_ready = 1'b1;

	// Clamp incoming register values to their legal ranges.
	always_comb begin
		if (cfg_data[rgblut_pkg::INTEN_W-1:0] > rgblut_pkg::INTENSITY_MAX) begin
			inten_new = rgblut_pkg::INTENSITY_MAX;
		end else begin
			inten_new = cfg_data[rgblut_pkg::INTEN_W-1:0];
		end
		if (cfg_data < rgblut_pkg::SIZE_MIN) begin
			size_new = rgblut_pkg::SIZE_MIN;
		end else if (cfg_data > SIZE_CAP) begin
			size_new = SIZE_CAP;
		end else begin
			size_new = cfg_data;
		end
	end

	// Configuration registers, kept in the forms the datapath uses.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inten_q   <= rgblut_pkg::INTENSITY_MAX;
			inten_c_q <= '0;
			size_m1_q <= SIZE_RST - 9'd1;
			size_m2_q <= SIZE_RST - 9'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rgblut_pkg::CFG_INTENSITY: begin
					inten_q   <= inten_new;
					inten_c_q <= rgblut_pkg::INTENSITY_MAX - inten_new;
				end
				rgblut_pkg::CFG_TABLE_SIZE: begin
					size_m1_q <= size_new - 9'd1;
					size_m2_q <= size_new - 9'd2;
				end
				default: begin
				end
			endcase
		end
	end

	// A stage loads when it is empty or the stage after it moves.
	always_comb begin
		adv[4] = !vld_s5 || res_ready;
		adv[3] = !vld_s4 || adv[4];
		adv[2] = !vld_s3 || adv[3];
		adv[1] = !vld_s2 || adv[2];
		adv[0] = !vld_s1 || adv[1];
	end

	assign item_ready = adv[0];
	assign res_valid  = vld_s5;

	// Valid bits; a table-write beat drops out after stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv[0]) begin
				vld_s1 <= item_valid;
			end
			if (adv[1]) begin
				vld_s2 <= vld_s1 && (cmd_s1 == rgblut_pkg::CMD_PIXEL);
			end
			if (adv[2]) begin
				vld_s3 <= vld_s2;
			end
			if (adv[3]) begin
				vld_s4 <= vld_s3;
			end
			if (adv[4]) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	// Command and write index ride in stage 1.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			cmd_s1   <= command;
			index_s1 <= table_index;
		end
	end

	assign index_ok = ({24'd0, index_s1} < 32'(TABLE_DEPTH));

	always_comb begin
		ctl.load     = adv;
		ctl.wr_en    = adv[1] && vld_s1 && (cmd_s1 == rgblut_pkg::CMD_WRITE) && index_ok;
		ctl.wr_index = index_s1;
	end

	rgblut_chan #(.TABLE_DEPTH(TABLE_DEPTH)) u_red (
		.clk     (clk),
		.ctl     (ctl),
		.pixel   (pixel_red),
		.entry   (entry_red),
		.size_m1 (size_m1_q),
		.size_m2 (size_m2_q),
		.inten   (inten_q),
		.inten_c (inten_c_q),
		.result  (out_red)
	);

	rgblut_chan #(.TABLE_DEPTH(TABLE_DEPTH)) u_green (
		.clk     (clk),
		.ctl     (ctl),
		.pixel   (pixel_green),
		.entry   (entry_green),
		.size_m1 (size_m1_q),
		.size_m2 (size_m2_q),
		.inten   (inten_q),
		.inten_c (inten_c_q),
		.result  (out_green)
	);

	rgblut_chan #(.TABLE_DEPTH(TABLE_DEPTH)) u_blue (
		.clk     (clk),
		.ctl     (ctl),
		.pixel   (pixel_blue),
		.entry   (entry_blue),
		.size_m1 (size_m1_q),
		.size_m2 (size_m2_q),
		.inten   (inten_q),
		.inten_c (inten_c_q),
		.result  (out_blue)
	);

endmodule

// ===== src/rgblut_chk.sv =====
// Port-level checker for rgb_1d_lut_interp_blend, with the bind that attaches it.
// Depends on rgblut_pkg and the top level's ports.
module rgblut_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_valid,
	input logic                              item_ready,
	input logic                              command,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [rgblut_pkg::PIX_W-1:0]      out_red,
	input logic [rgblut_pkg::PIX_W-1:0]      out_green,
	input logic [rgblut_pkg::PIX_W-1:0]      out_blue
);

	// With no result waiting, the pipeline can always take a beat.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> item_ready)
		else $error("input not ready while no result is pending");

	// A pixel beat shows up as a valid result when the result side stays open while it moves through the stages.
	a_pixel_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && (command == rgblut_pkg::CMD_PIXEL))
		##1 res_ready ##1 res_ready ##1 res_ready ##1 res_ready |=> res_valid)
		else $error("pixel result missing after pipeline latency");

	// A stalled result beat stays valid.
	a_res_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_res_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(out_red) && $stable(out_green)
			&& $stable(out_blue))
		else $error("result payload changed while stalled");

endmodule

bind rgb_1d_lut_interp_blend rgblut_chk u_chk (.*);

// ===== dv/rgb_1d_lut_interp_blend_tb.sv =====
// Self-checking testbench for rgb_1d_lut_interp_blend: random and directed table writes and
// pixels under many intensity and table-size settings, checked against an in-bench predictor.
// Depends on rgblut_pkg and the rgb_1d_lut_interp_blend RTL.
module rgb_1d_lut_interp_blend_tb;

	localparam int PIX_W   = rgblut_pkg::PIX_W;
	localparam int ENTRY_W = rgblut_pkg::ENTRY_W;
	localparam int SIZE_W  = rgblut_pkg::SIZE_W;
	localparam int INTEN_W = rgblut_pkg::INTEN_W;
	localparam int INDEX_W = rgblut_pkg::INDEX_W;

	localparam int         DEPTH         = 256;
	localparam logic [1:0] CH_RED        = 2'd0;
	localparam logic [1:0] CH_GREEN      = 2'd1;
	localparam logic [1:0] CH_BLUE       = 2'd2;
	localparam int         PIX_MAX       = 255;
	localparam int         Q_ONE         = 4096;
	localparam int         PERCENT       = 100;
	localparam int         ENTRY_MAX     = 8191;
	localparam int         SETTLE_CYCLES = rgblut_pkg::NUM_STAGES + 3;
	localparam int         NUM_PHASES    = 12;
	localparam int         PLANNED       = 9;
	localparam int         PHASE_BEATS   = 140;
	localparam int         BUSY_PHASE    = 5;

	typedef struct packed {
		logic               cmd;
		logic [INDEX_W-1:0] index;
		logic [ENTRY_W-1:0] ent_r;
		logic [ENTRY_W-1:0] ent_g;
		logic [ENTRY_W-1:0] ent_b;
		logic [PIX_W-1:0]   pix_r;
		logic [PIX_W-1:0]   pix_g;
		logic [PIX_W-1:0]   pix_b;
	} lut_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_pixel_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_valid   = 1'b0;
	logic               cfg_ready;
	logic               cfg_index   = rgblut_pkg::CFG_INTENSITY;
	logic [SIZE_W-1:0]  cfg_data    = '0;
	logic               item_valid  = 1'b0;
	logic               item_ready;
	logic               command     = rgblut_pkg::CMD_WRITE;
	logic [INDEX_W-1:0] table_index = '0;
	logic [ENTRY_W-1:0] entry_red   = '0;
	logic [ENTRY_W-1:0] entry_green = '0;
	logic [ENTRY_W-1:0] entry_blue  = '0;
	logic [PIX_W-1:0]   pixel_red   = '0;
	logic [PIX_W-1:0]   pixel_green = '0;
	logic [PIX_W-1:0]   pixel_blue  = '0;
	logic               res_valid;
	logic               res_ready   = 1'b0;
	logic [PIX_W-1:0]   out_red;
	logic [PIX_W-1:0]   out_green;
	logic [PIX_W-1:0]   out_blue;

	rgb_1d_lut_interp_blend dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.command     (command),
		.table_index (table_index),
		.entry_red   (entry_red),
		.entry_green (entry_green),
		.entry_blue  (entry_blue),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue)
	);

	// Beats waiting to be sent, and corrected pixels waiting to come out.
	lut_beat_t  pending_beats[$];
	rgb_pixel_t expected_pixels[$];

	// Shadow copy of the tables and the configuration registers.
	logic [ENTRY_W-1:0] lut_model [3][DEPTH];
	logic [INTEN_W-1:0] inten_model = rgblut_pkg::INTENSITY_MAX;
	logic [SIZE_W-1:0]  size_model  = 9'd256;

	int   idle_pct   = 37;
	logic beat_taken = 1'b0;
	int   mismatches = 0;
	int   n_writes   = 0;
	int   n_pixels   = 0;
	int   n_settings = 1;

	// Directed register settings; later phases pick theirs at random.
	int unsigned plan_inten [PLANNED] = '{0, 127, 101, 100, 50, 100, 1, 75, 100};
	int unsigned plan_size  [PLANNED] = '{256, 2, 0, 1, 3, 511, 257, 255, 17};

	initial begin
		forever #1 clk = ~clk;
	end

	// Interpolates one channel through its table and blends it with the input value.
	function automatic logic [PIX_W-1:0] blend_channel(input logic [1:0] ch,
			input logic [PIX_W-1:0] p);
		longint unsigned s, inten, pv, pos, i0, f, lo, hi, lutnum, num, r;
		s = 64'(size_model);
		if (s < 64'(rgblut_pkg::SIZE_MIN)) s = 64'(rgblut_pkg::SIZE_MIN);
		if (s > 64'(DEPTH)) s = 64'(DEPTH);
		inten = 64'(inten_model);
		if (inten > 64'(rgblut_pkg::INTENSITY_MAX)) inten = 64'(rgblut_pkg::INTENSITY_MAX);
		pv = 64'(p);
		pos = pv * (s - 64'd1);
		i0 = pos / 64'(PIX_MAX);
		if (i0 > s - 64'd2) i0 = s - 64'd2;
		f = pos - i0 * 64'(PIX_MAX);
		lo = 64'(lut_model[ch][i0[INDEX_W-1:0]]);
		hi = 64'(lut_model[ch][INDEX_W'(i0 + 64'd1)]);
		lutnum = lo * (64'(PIX_MAX) - f) + hi * f;
		num = pv * 64'(Q_ONE) * (64'(PERCENT) - inten) + lutnum * inten;
		r = num / 64'(Q_ONE * PERCENT);
		if (r > 64'(PIX_MAX)) r = 64'(PIX_MAX);
		return r[PIX_W-1:0];
	endfunction

	function automatic logic [ENTRY_W-1:0] random_entry();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? ENTRY_W'(ENTRY_MAX) : ENTRY_W'(0);
		return ENTRY_W'($urandom_range(0, ENTRY_MAX));
	endfunction

	function automatic logic [PIX_W-1:0] random_channel();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : PIX_W'(0);
		return PIX_W'($urandom_range(0, PIX_MAX));
	endfunction

	function automatic lut_beat_t table_write(input logic [INDEX_W-1:0] idx,
			input logic [ENTRY_W-1:0] r, input logic [ENTRY_W-1:0] g,
			input logic [ENTRY_W-1:0] b);
		lut_beat_t w;
		w.cmd   = rgblut_pkg::CMD_WRITE;
		w.index = idx;
		w.ent_r = r;
		w.ent_g = g;
		w.ent_b = b;
		w.pix_r = random_channel();
		w.pix_g = random_channel();
		w.pix_b = random_channel();
		return w;
	endfunction

	function automatic lut_beat_t pixel_beat(input logic [PIX_W-1:0] r,
			input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
		lut_beat_t w;
		w = table_write(INDEX_W'($urandom_range(0, DEPTH - 1)), random_entry(),
			random_entry(), random_entry());
		w.cmd   = rgblut_pkg::CMD_PIXEL;
		w.pix_r = r;
		w.pix_g = g;
		w.pix_b = b;
		return w;
	endfunction

	// About one beat in three rewrites a table entry; the rest are pixels.
	function automatic lut_beat_t random_beat();
		if ($urandom_range(0, 9) < 3)
			return table_write(INDEX_W'($urandom_range(0, DEPTH - 1)), random_entry(),
				random_entry(), random_entry());
		return pixel_beat(random_channel(), random_channel(), random_channel());
	endfunction

	// Appends one beat to the send queue.
	function automatic void add_beat(input lut_beat_t b);
		pending_beats.insert(pending_beats.size(), b);
	endfunction

	// Waits until every beat is sent and every pixel is back, then lets the pipeline empty.
	task automatic wait_idle();
		do @(posedge clk); while (pending_beats.size() != 0 || item_valid);
		do @(negedge clk); while (expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One beat on the configuration channel; the shadow register follows on acceptance.
	task automatic write_register(input logic idx, input logic [SIZE_W-1:0] value);
		repeat ($urandom_range(0, 2)) @(negedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == rgblut_pkg::CFG_INTENSITY)
			inten_model = value[INTEN_W-1:0];
		else
			size_model = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Item driver: holds a beat until it is taken, otherwise offers the next one or idles.
	always @(negedge clk) begin : item_driver
		lut_beat_t nb;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || beat_taken) begin
			if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				nb = pending_beats.pop_front();
				command     <= nb.cmd;
				table_index <= nb.index;
				entry_red   <= nb.ent_r;
				entry_green <= nb.ent_g;
				entry_blue  <= nb.ent_b;
				pixel_red   <= nb.pix_r;
				pixel_green <= nb.pix_g;
				pixel_blue  <= nb.pix_b;
				item_valid  <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result side stalls at random.
	always @(negedge clk) begin
		res_ready <= arst_n && ($urandom_range(0, 99) >= idle_pct);
	end

	// Monitor: predicts on each accepted item beat and checks each accepted result beat.
	always @(posedge clk) begin : beat_monitor
		rgb_pixel_t want;
		beat_taken <= item_valid && item_ready;
		if (arst_n && item_valid && item_ready) begin
			if (command == rgblut_pkg::CMD_WRITE) begin
				lut_model[CH_RED][table_index]   = entry_red;
				lut_model[CH_GREEN][table_index] = entry_green;
				lut_model[CH_BLUE][table_index]  = entry_blue;
				n_writes++;
			end else begin
				want.red   = blend_channel(CH_RED, pixel_red);
				want.green = blend_channel(CH_GREEN, pixel_green);
				want.blue  = blend_channel(CH_BLUE, pixel_blue);
				expected_pixels.insert(expected_pixels.size(), want);
				n_pixels++;
			end
		end
		if (arst_n && res_valid && res_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: result beat with no pixel pending: %0d %0d %0d",
					$time, out_red, out_green, out_blue);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				if (out_red !== want.red) begin
					$display("%0t: out_red expected %0d got %0d", $time, want.red, out_red);
					mismatches++;
				end
				if (out_green !== want.green) begin
					$display("%0t: out_green expected %0d got %0d",
						$time, want.green, out_green);
					mismatches++;
				end
				if (out_blue !== want.blue) begin
					$display("%0t: out_blue expected %0d got %0d", $time, want.blue, out_blue);
					mismatches++;
				end
			end
		end
	end

	// Stimulus: table fill, directed beats, then phases of random beats per setting.
	initial begin : stimulus
		int i;
		int phase;
		logic [INTEN_W-1:0] inten;
		logic [SIZE_W-1:0]  tsize;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry is written before any pixel can read it.
		for (i = 0; i < DEPTH; i++)
			add_beat(table_write(INDEX_W'(i), random_entry(), random_entry(),
				random_entry()));

		// Directed beats at the reset setting: entry and pixel extremes, exact positions.
		add_beat(table_write(INDEX_W'(0), ENTRY_W'(ENTRY_MAX), ENTRY_W'(0), ENTRY_W'(Q_ONE)));
		add_beat(table_write(INDEX_W'(DEPTH - 1), ENTRY_W'(0), ENTRY_W'(ENTRY_MAX),
			ENTRY_W'(Q_ONE)));
		add_beat(pixel_beat(8'd0, 8'd0, 8'd0));
		add_beat(pixel_beat(PIX_W'(PIX_MAX), PIX_W'(PIX_MAX), PIX_W'(PIX_MAX)));
		add_beat(pixel_beat(PIX_W'(PIX_MAX), 8'd0, 8'd128));
		add_beat(pixel_beat(8'd0, PIX_W'(PIX_MAX), 8'd1));
		add_beat(table_write(8'd128, ENTRY_W'(ENTRY_MAX), ENTRY_W'(ENTRY_MAX),
			ENTRY_W'(ENTRY_MAX)));
		add_beat(table_write(8'd129, ENTRY_W'(0), ENTRY_W'(0), ENTRY_W'(0)));
		add_beat(pixel_beat(8'd128, 8'd128, 8'd128));
		add_beat(pixel_beat(8'd129, 8'd127, 8'd130));

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			wait_idle();
			if (phase < PLANNED) begin
				inten = INTEN_W'(plan_inten[phase]);
				tsize = SIZE_W'(plan_size[phase]);
			end else begin
				inten = INTEN_W'($urandom_range(0, 127));
				tsize = SIZE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
					: $urandom_range(2, 40));
			end
			write_register(rgblut_pkg::CFG_INTENSITY, {2'b00, inten});
			write_register(rgblut_pkg::CFG_TABLE_SIZE, tsize);
			n_settings++;
			// One phase runs both channels flat out.
			idle_pct = (phase == BUSY_PHASE) ? 0 : 37;
			@(posedge clk);
			add_beat(pixel_beat(8'd0, 8'd0, 8'd0));
			add_beat(pixel_beat(PIX_W'(PIX_MAX), PIX_W'(PIX_MAX), PIX_W'(PIX_MAX)));
			add_beat(pixel_beat(8'd0, PIX_W'(PIX_MAX), 8'd128));
			for (i = 0; i < PHASE_BEATS; i++)
				add_beat(random_beat());
		end

		wait_idle();
		$display("Sent %0d table writes and %0d pixels over %0d register settings,",
			n_writes, n_pixels, n_settings);
		$display("including zero and saturated intensity and clamped table sizes.");
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("rgb_1d_lut_interp_blend_tb OK");
		end else begin
			$display("%0d mismatches, %0d pixels never returned",
				mismatches, expected_pixels.size());
			$display("rgb_1d_lut_interp_blend_tb NOT OK");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#400000;
		$display("%0t: timeout with %0d beats unsent and %0d pixels outstanding",
			$time, pending_beats.size(), expected_pixels.size());
		$display("rgb_1d_lut_interp_blend_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rgblut_pkg.sv
src/rgblut_ram.sv
src/rgblut_chan.sv
src/rgb_1d_lut_interp_blend.sv
src/rgblut_chk.sv
dv/rgb_1d_lut_interp_blend_tb.sv
